[hdl/cflsp_pkg.sv]
package cflsp_pkg;

  // Vector dimensions handled per item (2 or 3)
  localparam int DIMENSIONS = 3;

  localparam int VW      = 32;            // one velocity component / Q16.16 word
  localparam int SQW     = 2 * VW;        // exact square, Q32.32
  localparam int IDXW    = 16;            // substep counter width

  localparam int IN_DATA_W  = 3 * VW;                 // vel_x, vel_y, vel_z
  localparam int OUT_DATA_W = VW + IDXW + VW;         // substep, index, peak speed

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CFL      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME    = 3'd4;

  localparam logic [VW-1:0] RST_RADIUS   = 32'h0001_0000;
  localparam logic [VW-1:0] RST_CFL      = 32'h0001_0000;
  localparam logic [VW-1:0] RST_MIN_STEP = 32'h0000_0001;
  localparam logic [VW-1:0] RST_MAX_STEP = 32'h0001_0000;
  localparam logic [VW-1:0] RST_FRAME    = 32'h0001_0000;

  localparam logic [VW-1:0]   WORD_MAX  = '1;
  localparam logic [IDXW-1:0] INDEX_MAX = '1;

  // Iterative unit step counts: two radicand bits per root bit, one quotient bit per step
  localparam int SQRT_STEPS = SQW / 2;
  localparam int DIV_STEPS  = SQW;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [VW-1:0] radius;
    logic [VW-1:0] cfl;
    logic [VW-1:0] min_step;
    logic [VW-1:0] max_step;
    logic [VW-1:0] frame;
  } cfg_t;

  // Stage-1 control beside the lane registers
  typedef struct packed {
    logic valid;
    logic last;
  } lane_ctl_t;

  // Merge stage hand-off to the solver
  typedef struct packed {
    logic           start;
    logic [SQW-1:0] peak_sq;
  } sweep_t;

  typedef struct packed {
    logic [VW-1:0]   peak_speed;
    logic [IDXW-1:0] substep_index;
    logic [VW-1:0]   substep;
    logic            frame_done;
  } result_t;

endpackage

[hdl/cflsp_lane.sv]
module cflsp_lane (
  input  logic                     clk,
  input  logic                     en,
  input  logic [cflsp_pkg::VW-1:0] vel,
  output logic [cflsp_pkg::SQW-1:0] sq_r
);
  import cflsp_pkg::*;

  logic [VW-1:0] mag;

  // Magnitude of the signed component; the most negative value maps to 2^31
  assign mag = vel[VW-1] ? (~vel + VW'(1)) : vel;

  // Register the exact square
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= SQW'(mag) * SQW'(mag);
    end
  end

endmodule

[hdl/cflsp_merge.sv]
module cflsp_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cflsp_pkg::lane_ctl_t        ctl,
  input  logic [cflsp_pkg::DIMENSIONS-1:0][cflsp_pkg::SQW-1:0] lane_sq,
  output cflsp_pkg::sweep_t           sweep_r
);
  import cflsp_pkg::*;

  logic [SQW-1:0] peak_r;
  logic [SQW-1:0] sum;
  logic [SQW-1:0] peak_nxt;

  // Add the lane squares and keep the larger of sum and running peak
  always_comb begin
    sum = '0;
    for (int i = 0; i < DIMENSIONS; i++) begin
      sum = sum + lane_sq[i];
    end
    peak_nxt = (sum > peak_r) ? sum : peak_r;
  end

  // Track the peak; hand it over and restart on the last beat of a sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r          <= '0;
      sweep_r.start   <= 1'b0;
      sweep_r.peak_sq <= '0;
    end else begin
      sweep_r.start <= 1'b0;
      if (ctl.valid) begin
        if (ctl.last) begin
          peak_r          <= '0;
          sweep_r.start   <= 1'b1;
          sweep_r.peak_sq <= peak_nxt;
        end else begin
          peak_r <= peak_nxt;
        end
      end
    end
  end

endmodule

[hdl/cflsp_solver.sv]
module cflsp_solver (
  input  logic                clk,
  input  logic                rst_n,
  input  cflsp_pkg::cfg_t     cfg,
  input  cflsp_pkg::sweep_t   sweep,
  input  logic                out_ready,
  output logic                out_valid_r,
  output cflsp_pkg::result_t  out_r,
  output logic                load
);
  import cflsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SQRT  = 5'b00010,
    S_DIV   = 5'b00100,
    S_CLAMP = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t          state_r;
  logic [CNT_W-1:0] cnt_r;

  // Square root unit
  logic [SQW-1:0]  x_r;
  logic [VW:0]     rem_r;
  logic [VW-1:0]   root_r;
  logic [VW+2:0]   rem_sh;
  logic [VW+2:0]   trial;
  logic            sq_ge;
  logic [VW:0]     rem_nxt;
  logic [VW-1:0]   root_nxt;

  // Divider
  logic [SQW-1:0]  prod_r;
  logic [SQW-1:0]  dvd_r;
  logic [VW-1:0]   drem_r;
  logic [VW:0]     drem_sh;
  logic            dv_ge;
  logic [VW-1:0]   drem_nxt;
  logic [SQW-1:0]  dvd_nxt;

  // Step selection and frame state
  logic [VW-1:0]   step_raw;
  logic [VW-1:0]   step_nxt;
  logic [VW-1:0]   remt_nxt;
  logic [VW-1:0]   step_r;
  logic [VW-1:0]   remt_r;
  logic [VW-1:0]   sub;
  logic [VW:0]     newel;
  logic            done;
  logic [VW-1:0]   elapsed_r;
  logic [IDXW-1:0] counter_r;
  logic [IDXW-1:0] counter_nxt;

  // One root bit per step: bring down two radicand bits, try (4*root + 1)
  always_comb begin
    rem_sh   = {rem_r, x_r[SQW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    sq_ge    = rem_sh >= trial;
    rem_nxt  = sq_ge ? (VW+1)'(rem_sh - trial) : rem_sh[VW:0];
    root_nxt = {root_r[VW-2:0], sq_ge};
  end

  // One quotient bit per step, shifted in behind the dividend
  always_comb begin
    drem_sh  = {drem_r, dvd_r[SQW-1]};
    dv_ge    = drem_sh >= {1'b0, root_r};
    drem_nxt = dv_ge ? VW'(drem_sh - {1'b0, root_r}) : drem_sh[VW-1:0];
    dvd_nxt  = {dvd_r[SQW-2:0], dv_ge};
  end

  // Saturate the quotient, clamp, and work out the time left in the frame
  always_comb begin
    if (root_r == '0 || dvd_r[SQW-1:VW] != '0) begin
      step_raw = WORD_MAX;
    end else begin
      step_raw = dvd_r[VW-1:0];
    end
    if (step_raw < cfg.min_step) begin
      step_nxt = cfg.min_step;
    end else if (step_raw > cfg.max_step) begin
      step_nxt = cfg.max_step;
    end else begin
      step_nxt = step_raw;
    end
    remt_nxt = (elapsed_r < cfg.frame) ? (cfg.frame - elapsed_r) : '0;
  end

  // Shorten near the frame end; 1.5 steps reaching it is 3*step >= 2*remaining
  always_comb begin
    if (step_r >= remt_r) begin
      sub = remt_r;
    end else if (({2'b00, step_r} + {1'b0, step_r, 1'b0}) >= {1'b0, remt_r, 1'b0}) begin
      sub = remt_r >> 1;
    end else begin
      sub = step_r;
    end
    newel       = {1'b0, elapsed_r} + {1'b0, sub};
    done        = newel >= {1'b0, cfg.frame};
    counter_nxt = (counter_r == INDEX_MAX) ? counter_r : counter_r + IDXW'(1);
    load        = (state_r == S_FIN) && (!out_valid_r || out_ready);
  end

  // Sequencer and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      elapsed_r   <= '0;
      counter_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Raise on a load, drop once the result beat is taken
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (sweep.start) begin
            state_r <= S_SQRT;
            cnt_r   <= '0;
          end
        end
        S_SQRT: begin
          if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
            state_r <= S_DIV;
            cnt_r   <= '0;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_DIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (load) begin
            state_r <= S_IDLE;
            if (done) begin
              elapsed_r <= '0;
              counter_r <= '0;
            end else begin
              elapsed_r <= newel[VW-1:0];
              counter_r <= counter_nxt;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        x_r    <= sweep.peak_sq;
        rem_r  <= '0;
        root_r <= '0;
        prod_r <= SQW'(cfg.radius) * SQW'(cfg.cfl);
      end
      S_SQRT: begin
        x_r    <= {x_r[SQW-3:0], 2'b00};
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        dvd_r  <= prod_r;
        drem_r <= '0;
      end
      S_DIV: begin
        dvd_r  <= dvd_nxt;
        drem_r <= drem_nxt;
      end
      S_CLAMP: begin
        step_r <= step_nxt;
        remt_r <= remt_nxt;
      end
      S_FIN: begin
        if (load) begin
          out_r.substep       <= sub;
          out_r.substep_index <= counter_nxt;
          out_r.frame_done    <= done;
          out_r.peak_speed    <= root_r;
        end
      end
      default: begin
      end
    endcase
  end

  // A new sweep never arrives while a step is being worked out
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !sweep.start)
    else $error("sweep start while solver busy");

  // The chosen substep never exceeds the clamped CFL step
  assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (sub <= step_r))
    else $error("substep above clamped step");

  // Frame state returns to zero after a frame-done result
  assert property (@(posedge clk) disable iff (!rst_n)
    (load && done) |=> (elapsed_r == '0 && counter_r == '0))
    else $error("frame state not cleared at frame end");

endmodule

[hdl/cfl_substep_planner_core.sv]
// Result: an item without tlast gives no result; after the last beat of a sweep the
//   sweep passes the lane and merge registers, then the 32 square root and 64 divider
//   single-bit iterations, the clamp and the final state, where the result is loaded.
// Throughput: one beat per cycle within a sweep; after a last beat the input holds off
//   until the result is loaded, longer while an earlier result still waits.
// Reset: synchronous, active low; registers return to their defaults, peak, elapsed
//   frame time and substep count clear, no result pending.
module cfl_substep_planner_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [cflsp_pkg::IN_DATA_W-1:0]       in_tdata,   // vel_x, vel_y, vel_z
  input  logic                                  in_tlast,   // last_of_sweep
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [cflsp_pkg::OUT_DATA_W-1:0]      out_tdata,  // substep, substep_index, peak_speed
  output logic                                  out_tlast,  // frame_done
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [cflsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cflsp_pkg::VW-1:0]              cfg_data
);
  import cflsp_pkg::*;

  cfg_t       cfg_r;
  logic       busy_r;
  logic       in_beat;
  lane_ctl_t  ctl_r;
  sweep_t     sweep;
  result_t    res;
  logic       res_valid;
  logic       load;
  logic [DIMENSIONS-1:0][VW-1:0]  vel;
  logic [DIMENSIONS-1:0][SQW-1:0] lane_sq;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy_r;
  assign in_beat   = in_tvalid && in_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius   <= RST_RADIUS;
      cfg_r.cfl      <= RST_CFL;
      cfg_r.min_step <= RST_MIN_STEP;
      cfg_r.max_step <= RST_MAX_STEP;
      cfg_r.frame    <= RST_FRAME;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS:   cfg_r.radius   <= cfg_data;
        REG_CFL:      cfg_r.cfl      <= cfg_data;
        REG_MIN_STEP: cfg_r.min_step <= cfg_data;
        REG_MAX_STEP: cfg_r.max_step <= cfg_data;
        REG_FRAME:    cfg_r.frame    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Hold off input from a last beat until its result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      ctl_r.valid <= in_beat;
      ctl_r.last  <= in_tlast;
      if (in_beat && in_tlast) begin
        busy_r <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
    end
  end

  // One squaring lane per component
  for (genvar d = 0; d < DIMENSIONS; d++) begin : g_lane
    assign vel[d] = in_tdata[d*VW +: VW];
    cflsp_lane u_lane (
      .clk  (clk),
      .en   (in_beat),
      .vel  (vel[d]),
      .sq_r (lane_sq[d])
    );
  end

  cflsp_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl_r),
    .lane_sq (lane_sq),
    .sweep_r (sweep)
  );

  cflsp_solver u_solver (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .sweep       (sweep),
    .out_ready   (out_tready),
    .out_valid_r (res_valid),
    .out_r       (res),
    .load        (load)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {res.peak_speed, res.substep_index, res.substep};
  assign out_tlast  = res.frame_done;

  // A result only follows a last beat
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid) |-> $past(busy_r))
    else $error("result without a finished sweep");

  // No beat is taken once a last beat has gone in
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_tlast) |=> !in_tready)
    else $error("input taken while step in progress");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cflsp_pkg::*;

  localparam int QUIET_LIMIT   = 4000;  // cycles with no beat on any channel
  localparam int HOLD_CYCLES   = 500;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 110;   // extra drain time once every result is in
  localparam int PHASE_BEATS   = 175;
  localparam int RAND_PHASES   = 6;

  typedef struct {
    logic [VW-1:0] vx;
    logic [VW-1:0] vy;
    logic [VW-1:0] vz;
    logic          last;
  } vel_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // vel_x, vel_y, vel_z
  logic                  in_tlast = 1'b0; // last_of_sweep
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // substep, substep_index, peak_speed
  logic                  out_tlast;       // frame_done
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [VW-1:0]         cfg_data = '0;

  cfl_substep_planner_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shared between the stimulus, driver, receiver and monitor
  vel_beat_t velocity_q[$];
  result_t   substep_q[$];
  int        beats_queued = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        quiet = 0;
  bit        in_took = 1'b0;

  // Planner mirror: registers and running state
  cfg_t             regs;
  logic [SQW-1:0]   peak_sq;
  logic [VW-1:0]    elapsed;
  logic [IDXW-1:0]  step_count;

  function automatic void flag_error(string msg);
    if (mismatches < 10) $display("ERROR at %0t: %s", $time, msg);
    mismatches++;
  endfunction

  function automatic logic [SQW-1:0] square_mag(logic [VW-1:0] c);
    logic [VW-1:0] mag;
    mag = c[VW-1] ? (~c + 1'b1) : c;
    return {{VW{1'b0}}, mag} * {{VW{1'b0}}, mag};
  endfunction

  // Floor square root, one result bit per pass from the top
  function automatic logic [VW-1:0] root_floor(logic [SQW-1:0] x);
    logic [VW-1:0] r;
    logic [VW-1:0] t;
    r = '0;
    for (int b = VW - 1; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if ({{VW{1'b0}}, t} * {{VW{1'b0}}, t} <= x) r = t;
    end
    return r;
  endfunction

  // Fold one velocity beat into the sweep peak; plan the substep on the last beat
  function automatic void plan_beat(input vel_beat_t b, output logic has_res,
                                    output result_t res);
    logic [SQW-1:0] sq;
    logic [SQW-1:0] quo;
    logic [VW-1:0]  speed;
    logic [VW-1:0]  step;
    logic [VW-1:0]  remaining;
    logic [VW-1:0]  sub;
    logic [VW:0]    new_elapsed;
    logic           done;
    sq = square_mag(b.vx) + square_mag(b.vy);
    if (DIMENSIONS == 3) sq += square_mag(b.vz);
    if (sq > peak_sq) peak_sq = sq;
    has_res = b.last;
    res = '0;
    if (!b.last) return;

    speed = root_floor(peak_sq);
    if (speed == '0) begin
      step = WORD_MAX;
    end else begin
      quo = ({{VW{1'b0}}, regs.radius} * {{VW{1'b0}}, regs.cfl}) / {{VW{1'b0}}, speed};
      step = (quo > {{VW{1'b0}}, WORD_MAX}) ? WORD_MAX : quo[VW-1:0];
    end
    if (step < regs.min_step) step = regs.min_step;
    else if (step > regs.max_step) step = regs.max_step;

    remaining = (elapsed < regs.frame) ? regs.frame - elapsed : '0;
    if (step >= remaining)
      sub = remaining;
    else if (64'd3 * {{VW{1'b0}}, step} >= 64'd2 * {{VW{1'b0}}, remaining})
      sub = remaining >> 1;
    else
      sub = step;

    new_elapsed = {1'b0, elapsed} + {1'b0, sub};
    done = new_elapsed >= {1'b0, regs.frame};
    if (step_count != INDEX_MAX) step_count++;

    res.substep       = sub;
    res.substep_index = step_count;
    res.frame_done    = done;
    res.peak_speed    = speed;

    peak_sq = '0;
    if (done) begin
      elapsed = '0;
      step_count = '0;
    end else begin
      elapsed = new_elapsed[VW-1:0];
    end
  endfunction

  // Monitor: check results, track register writes, predict accepted beats, watchdog
  always @(posedge clk) begin : monitor
    vel_beat_t b;
    result_t   want;
    logic      has_res;
    if (!rst_n) begin
      regs = '{radius: RST_RADIUS, cfl: RST_CFL, min_step: RST_MIN_STEP,
               max_step: RST_MAX_STEP, frame: RST_FRAME};
      peak_sq = '0;
      elapsed = '0;
      step_count = '0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (substep_q.size() == 0) begin
          flag_error($sformatf("result with none expected: data %h done %b",
                               out_tdata, out_tlast));
        end else begin
          want = substep_q.pop_front();
          if (out_tdata[VW-1:0] !== want.substep)
            flag_error($sformatf("substep exp %h got %h", want.substep, out_tdata[VW-1:0]));
          if (out_tdata[VW+IDXW-1:VW] !== want.substep_index)
            flag_error($sformatf("substep_index exp %0d got %0d", want.substep_index,
                                 out_tdata[VW+IDXW-1:VW]));
          if (out_tlast !== want.frame_done)
            flag_error($sformatf("frame_done exp %b got %b", want.frame_done, out_tlast));
          if (out_tdata[OUT_DATA_W-1:VW+IDXW] !== want.peak_speed)
            flag_error($sformatf("peak_speed exp %h got %h", want.peak_speed,
                                 out_tdata[OUT_DATA_W-1:VW+IDXW]));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RADIUS:   regs.radius   = cfg_data;
          REG_CFL:      regs.cfl      = cfg_data;
          REG_MIN_STEP: regs.min_step = cfg_data;
          REG_MAX_STEP: regs.max_step = cfg_data;
          REG_FRAME:    regs.frame    = cfg_data;
          default: ;
        endcase
      end

      in_took = in_tvalid && in_tready;
      if (in_took) begin
        b.vx = in_tdata[VW-1:0];
        b.vy = in_tdata[2*VW-1:VW];
        b.vz = in_tdata[3*VW-1:2*VW];
        b.last = in_tlast;
        plan_beat(b, has_res, want);
        if (has_res) substep_q.push_back(want);
      end
    end

    if (in_took || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("cfl_substep_planner_core test failed");
        $finish;
      end
    end
  end

  // Driver: offer beats in bursts, hold each until taken
  int burst_left = 0;
  int gap_left = 0;

  always @(negedge clk) begin : driver
    logic      nv;
    vel_beat_t b;
    nv = in_tvalid && !in_took;
    if (!nv) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (velocity_q.size() != 0) begin
        b = velocity_q.pop_front();
        nv = 1'b1;
        in_tdata <= {b.vz, b.vy, b.vx};
        in_tlast <= b.last;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
    in_tvalid <= nv;
  end

  // Receiver: stall pattern in modes, plus a long hold-off every so many results
  int hold_left = 0;
  int next_hold_at = 15;
  int mode = 0;
  int mode_left = 0;

  always @(negedge clk) begin : receiver
    logic rdy;
    if (hold_left != 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (results_seen >= next_hold_at) begin
      hold_left = HOLD_CYCLES;
      next_hold_at += 80;
      rdy = 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (mode)
        0: rdy = 1'b1;
        1: rdy = ($urandom_range(0, 1) == 1);
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
    end
    out_tready <= rdy;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_beat(logic [VW-1:0] vx, logic [VW-1:0] vy, logic [VW-1:0] vz,
                            logic last);
    velocity_q.push_back('{vx: vx, vy: vy, vz: vz, last: last});
    beats_queued++;
  endtask

  // Wait for every queued beat and expected result, then let the pipeline drain
  task automatic settle();
    while (velocity_q.size() != 0 || in_tvalid || substep_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [VW-1:0] rand_comp(int sh);
    logic signed [VW-1:0] v;
    v = $urandom;
    return v >>> sh;
  endfunction

  function automatic logic [VW-1:0] pick_value(logic [VW-1:0] lo_ext, logic [VW-1:0] hi_ext,
                                               int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 7))
      0: return lo_ext;
      1: return hi_ext;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_RADIUS,   pick_value('0, WORD_MAX, 32'h1000, 32'h40000));
    write_reg(REG_CFL,      pick_value('0, WORD_MAX, 32'h1000, 32'h10000));
    write_reg(REG_MIN_STEP, pick_value('0, WORD_MAX, 0, 32'h800));
    write_reg(REG_MAX_STEP, pick_value('0, WORD_MAX, 32'h400, 32'h80000));
    write_reg(REG_FRAME,    pick_value(32'd1, WORD_MAX, 32'h800, 32'h200000));
    end_writes();
  endtask

  // One well-formed sweep with random content and a random speed scale
  task automatic random_sweep();
    int n;
    int sh;
    int kind;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    kind = $urandom_range(0, 15);
    sh = $urandom_range(8, 22);
    for (int k = 0; k < n; k++) begin
      if (kind == 0)
        queue_beat('0, '0, '0, k == n - 1);
      else if (kind <= 2)
        queue_beat($urandom, $urandom, $urandom, k == n - 1);
      else
        queue_beat(rand_comp(sh + $urandom_range(0, 4)), rand_comp(sh + $urandom_range(0, 4)),
                   rand_comp(sh + $urandom_range(0, 4)), k == n - 1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero speed takes the whole frame
    queue_beat('0, '0, '0, 1'b1);
    // Largest magnitudes in one sweep, then a step clamped to the minimum
    queue_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    queue_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    queue_beat('0, '0, 32'h0002_0000, 1'b1);
    // Speed 2.0: plain CFL step, then the step covers the rest of the frame
    queue_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_beat(32'h0002_0000, '0, '0, 1'b1);
    queue_beat('0, 32'hFFFE_0000, '0, 1'b1);
    // Speed 1.25: one and a half steps reach the end, so halve the remainder
    queue_beat(32'h0001_4000, '0, '0, 1'b1);
    queue_beat('0, '0, 32'hFFFE_C000, 1'b1);
    settle();

    // Widest registers: the quotient saturates; writes past the map are dropped
    write_reg(REG_RADIUS, WORD_MAX);
    write_reg(REG_CFL, WORD_MAX);
    write_reg(REG_MIN_STEP, '0);
    write_reg(REG_MAX_STEP, WORD_MAX);
    write_reg(REG_FRAME, WORD_MAX);
    for (int r = REG_FRAME + 1; r < 2 ** CFG_IDX_W; r++)
      write_reg(CFG_IDX_W'(r), $urandom);
    end_writes();
    queue_beat(32'd1, '0, '0, 1'b1);
    queue_beat(32'hFFFF_FFFF, 32'd1, 32'h0000_0003, 1'b1);
    settle();

    // Minimum above maximum, zero radius: the minimum wins, a zero-speed sweep takes the maximum
    write_reg(REG_RADIUS, '0);
    write_reg(REG_MIN_STEP, 32'h0003_0000);
    write_reg(REG_MAX_STEP, 32'h0001_0000);
    write_reg(REG_FRAME, 32'h0010_0000);
    end_writes();
    queue_beat(32'h0000_8000, 32'h0000_8000, '0, 1'b1);
    queue_beat(32'hFFF0_0000, '0, 32'h0010_0000, 1'b0);
    queue_beat('0, 32'h0000_0010, '0, 1'b1);
    queue_beat('0, '0, '0, 1'b1);
    settle();

    // Frame shortened below the elapsed time: zero step, frame closes
    write_reg(REG_FRAME, 32'd1);
    end_writes();
    queue_beat(32'h0001_0000, '0, '0, 1'b1);
    queue_beat(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
    settle();

    // Random phases, each under fresh register settings
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_config();
      beats_queued = 0;
      while (beats_queued < PHASE_BEATS) random_sweep();
      settle();
    end

    if (substep_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", substep_q.size()));
    if (mismatches == 0)
      $display("cfl_substep_planner_core test passed");
    else
      $display("cfl_substep_planner_core test failed");
    $finish;
  end

endmodule
